// ----- rtl/pfba_pkg.sv -----
// Shared types, codes and control records for the page frame bitmap allocator.
package pfba_pkg;

	localparam int TOTAL_W = 13;
	localparam int PAGE_W  = 12;
	localparam int LEN_W   = 11;
	localparam int BASE_W  = 14;

	localparam logic [1:0] OP_ALLOC   = 2'd0;
	localparam logic [1:0] OP_FREE    = 2'd1;
	localparam logic [1:0] OP_RESERVE = 2'd2;
	localparam logic [1:0] OP_NONE    = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BUSY   = 2'd1;
	localparam logic [1:0] ST_RANGE  = 2'd2;
	localparam logic [1:0] ST_DOUBLE = 2'd3;

	typedef enum logic [1:0] {
		RD_RUN,
		RD_HINT,
		RD_CNT
	} rd_sel_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DISPATCH,
		S_ALIGN,
		S_CAND,
		S_RUN_RD,
		S_RUN_CHK,
		S_MARK,
		S_HINT_RD,
		S_HINT_CHK,
		S_CNT_RD,
		S_CNT_CHK,
		S_DONE
	} state_t;

	typedef struct packed {
		logic       latch;
		logic       align_step;
		logic       cand_next;
		logic       run_init;
		logic       off_inc;
		rd_sel_t    rd_sel;
		logic       wr_en;
		logic       wr_clr;
		logic       clr_step;
		logic       set_result;
		logic       hint_inc;
		logic       hint_min;
		logic       cnt_init;
		logic       cnt_step;
		logic       st_en;
		logic [1:0] st_code;
		logic       load_out;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       len_bad;
		logic       range_bad;
		logic       align_done;
		logic       cand_fail;
		logic       run_last;
		logic       bit_used;
		logic       hint_end;
		logic       cnt_end;
		logic       clr_end;
		logic       out_busy;
	} stat_t;

endpackage

// ----- rtl/pfba_datapath.sv -----
// Datapath: usage map memory, scan pointers, counters and result register.
module pfba_datapath import pfba_pkg::*; #(
	parameter int MAX_PAGES = 4096,
	parameter int MAX_RUN   = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output stat_t               stat,
	input  logic                cfg_valid,
	input  logic [TOTAL_W-1:0]  cfg_data,
	input  logic [1:0]          in_op,
	input  logic [PAGE_W-1:0]   in_page,
	input  logic [LEN_W-1:0]    in_len,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          out_status,
	output logic [PAGE_W-1:0]   out_page,
	output logic [TOTAL_W-1:0]  out_free
);

	localparam int AW = $clog2(MAX_PAGES);
	localparam logic [TOTAL_W-1:0] CAPV =
		(MAX_PAGES < (1 << TOTAL_W)) ? TOTAL_W'(MAX_PAGES) : {TOTAL_W{1'b1}};
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_PAGES - 1);

	logic               mem [MAX_PAGES];
	logic               rdata_q;
	logic [TOTAL_W-1:0] total_q, eff, hint_q, cnt_q, free_q;
	logic [1:0]         op_q, status_q, ost_q;
	logic [PAGE_W-1:0]  page_q, result_q, opage_q;
	logic [LEN_W-1:0]   len_q, off_q;
	logic [BASE_W-1:0]  base_q, eff_b, run_sum;
	logic [AW-1:0]      clr_q, raddr, waddr;
	logic [TOTAL_W-1:0] ofree_q;
	logic               ovalid_q;

	assign eff     = (total_q > CAPV) ? CAPV : total_q;
	assign eff_b   = {1'b0, eff};
	assign run_sum = base_q + {3'b0, off_q};

	always_comb begin
		case (cmd.rd_sel)
			RD_RUN:  raddr = AW'(run_sum);
			RD_HINT: raddr = AW'(hint_q);
			RD_CNT:  raddr = AW'(cnt_q);
			default: raddr = AW'(run_sum);
		endcase
		waddr = cmd.wr_clr ? clr_q : AW'(run_sum);
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en)
			mem[waddr] <= !cmd.wr_clr && (op_q != OP_FREE);
		rdata_q <= mem[raddr];
	end

	always_comb begin
		stat.op         = op_q;
		stat.len_bad    = (len_q == '0) || ({2'b0, len_q} > TOTAL_W'(MAX_RUN));
		stat.range_bad  = ({1'b0, page_q} >= eff) ||
			({2'b0, len_q} > eff - {1'b0, page_q});
		stat.align_done = base_q >= {1'b0, hint_q};
		stat.cand_fail  = (base_q >= eff_b) || ({3'b0, len_q} > eff_b - base_q);
		stat.run_last   = off_q == len_q - LEN_W'(1);
		stat.bit_used   = rdata_q;
		stat.hint_end   = hint_q >= eff;
		stat.cnt_end    = cnt_q >= eff;
		stat.clr_end    = clr_q == LAST_ADDR;
		stat.out_busy   = ovalid_q && !out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= TOTAL_W'(4096);
			hint_q   <= '0;
			clr_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (cfg_valid)
				total_q <= cfg_data;
			if (cmd.clr_step)
				clr_q <= clr_q + AW'(1);
			if (cmd.hint_inc)
				hint_q <= hint_q + TOTAL_W'(1);
			else if (cmd.hint_min && ({1'b0, page_q} < hint_q))
				hint_q <= {1'b0, page_q};
			if (cmd.load_out)
				ovalid_q <= 1'b1;
			else if (out_ready)
				ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q     <= in_op;
			page_q   <= in_page;
			len_q    <= in_len;
			base_q   <= (in_op == OP_ALLOC) ? '0 : {2'b0, in_page};
			status_q <= ST_OK;
			result_q <= '0;
		end
		if (cmd.align_step)
			base_q <= base_q + {3'b0, len_q};
		if (cmd.cand_next) begin
			base_q <= base_q + {3'b0, len_q};
			off_q  <= '0;
		end
		if (cmd.run_init)
			off_q <= '0;
		if (cmd.off_inc)
			off_q <= off_q + LEN_W'(1);
		if (cmd.set_result)
			result_q <= base_q[PAGE_W-1:0];
		if (cmd.st_en)
			status_q <= cmd.st_code;
		if (cmd.cnt_init) begin
			cnt_q  <= '0;
			free_q <= '0;
		end
		if (cmd.cnt_step) begin
			cnt_q <= cnt_q + TOTAL_W'(1);
			if (!rdata_q)
				free_q <= free_q + TOTAL_W'(1);
		end
		if (cmd.load_out) begin
			ost_q   <= status_q;
			opage_q <= result_q;
			ofree_q <= free_q;
		end
	end

	assign out_valid  = ovalid_q;
	assign out_status = ost_q;
	assign out_page   = opage_q;
	assign out_free   = ofree_q;

endmodule

// ----- rtl/pfba_ctrl.sv -----
// Controller: sequencer over the usage map for alloc, free, reserve and recount.
module pfba_ctrl import pfba_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_CLEAR;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.rd_sel = RD_RUN;
		in_ready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.wr_en    = 1'b1;
				cmd.wr_clr   = 1'b1;
				cmd.clr_step = 1'b1;
				if (stat.clr_end)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (stat.op == OP_NONE) begin
					cmd.st_en = 1'b1; cmd.st_code = ST_BUSY;
					cmd.cnt_init = 1'b1; state_d = S_CNT_RD;
				end else if (stat.len_bad) begin
					cmd.st_en = 1'b1; cmd.st_code = ST_RANGE;
					cmd.cnt_init = 1'b1; state_d = S_CNT_RD;
				end else if (stat.op == OP_ALLOC) begin
					state_d = S_ALIGN;
				end else if (stat.range_bad) begin
					cmd.st_en = 1'b1; cmd.st_code = ST_RANGE;
					cmd.cnt_init = 1'b1; state_d = S_CNT_RD;
				end else begin
					cmd.run_init = 1'b1; state_d = S_RUN_RD;
				end
			end
			S_ALIGN: begin
				if (stat.align_done)
					state_d = S_CAND;
				else
					cmd.align_step = 1'b1;
			end
			S_CAND: begin
				if (stat.cand_fail) begin
					cmd.st_en = 1'b1; cmd.st_code = ST_BUSY;
					state_d = S_HINT_RD;
				end else begin
					cmd.run_init = 1'b1; state_d = S_RUN_RD;
				end
			end
			S_RUN_RD: begin
				cmd.rd_sel = RD_RUN;
				state_d    = S_RUN_CHK;
			end
			S_RUN_CHK: begin
				if (stat.bit_used != (stat.op == OP_FREE)) begin
					if (stat.op == OP_ALLOC) begin
						cmd.cand_next = 1'b1; state_d = S_CAND;
					end else begin
						cmd.st_en   = 1'b1;
						cmd.st_code = (stat.op == OP_FREE) ? ST_DOUBLE : ST_BUSY;
						cmd.cnt_init = 1'b1; state_d = S_CNT_RD;
					end
				end else if (stat.run_last) begin
					cmd.run_init = 1'b1; state_d = S_MARK;
				end else begin
					cmd.off_inc = 1'b1; state_d = S_RUN_RD;
				end
			end
			S_MARK: begin
				cmd.wr_en = 1'b1;
				if (stat.run_last) begin
					if (stat.op == OP_ALLOC) begin
						cmd.set_result = 1'b1; state_d = S_HINT_RD;
					end else begin
						cmd.hint_min = (stat.op == OP_FREE);
						cmd.cnt_init = 1'b1; state_d = S_CNT_RD;
					end
				end else begin
					cmd.off_inc = 1'b1;
				end
			end
			S_HINT_RD: begin
				cmd.rd_sel = RD_HINT;
				if (stat.hint_end) begin
					cmd.cnt_init = 1'b1; state_d = S_CNT_RD;
				end else begin
					state_d = S_HINT_CHK;
				end
			end
			S_HINT_CHK: begin
				if (stat.bit_used) begin
					cmd.hint_inc = 1'b1; state_d = S_HINT_RD;
				end else begin
					cmd.cnt_init = 1'b1; state_d = S_CNT_RD;
				end
			end
			S_CNT_RD: begin
				cmd.rd_sel = RD_CNT;
				state_d = stat.cnt_end ? S_DONE : S_CNT_CHK;
			end
			S_CNT_CHK: begin
				cmd.cnt_step = 1'b1;
				state_d      = S_CNT_RD;
			end
			S_DONE: begin
				if (!stat.out_busy) begin
					cmd.load_out = 1'b1; state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ----- rtl/page_frame_bitmap_allocator.sv -----
// Top level of the page frame bitmap allocator: ports and controller/datapath wiring.
//
//  channel  | signals                          | moves
//  ---------+----------------------------------+------------------------------------
//  s_axis   | s_tvalid s_tready s_tdata s_tuser| one request: op, first page, length
//  m_axis   | m_tvalid m_tready m_tdata m_tuser| one response per request
//  cfg      | cfg_valid cfg_ready cfg_data     | write of total_pages
//
// Accept and decode pass through the idle and dispatch states. Free/reserve then read and
// check each page and mark it. Alloc steps to the first aligned start at or above the hint,
// tries candidates (a bound check, then a read and check per bit), marks, then advances
// the hint (read and check a page). Every request ends with a recount below the total
// (read and check a page), then a response load. Reset clears the map with s_tready low.
// A stalled response holds the block in its finish state; no request is taken until it drains.
module page_frame_bitmap_allocator import pfba_pkg::*; #(
	parameter int MAX_PAGES = 4096,
	parameter int MAX_RUN   = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [23:0]         s_tdata,   // start_page[11:0], run_length[22:12]
	input  logic [1:0]          s_tuser,   // operation[1:0]
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [31:0]         m_tdata,   // result_page[11:0], free_pages[24:12]
	output logic [1:0]          m_tuser,   // status[1:0]
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [TOTAL_W-1:0]  cfg_data   // total_pages
);

	cmd_t               cmd;
	stat_t              stat;
	logic [PAGE_W-1:0]  out_page;
	logic [TOTAL_W-1:0] out_free;

	// register writes land at any time; the user must issue them only while idle, which the block does not enforce
	assign cfg_ready = 1'b1;

	pfba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pfba_datapath #(
		.MAX_PAGES (MAX_PAGES),
		.MAX_RUN   (MAX_RUN)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.in_op      (s_tuser),
		.in_page    (s_tdata[11:0]),
		.in_len     (s_tdata[22:12]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (m_tuser),
		.out_page   (out_page),
		.out_free   (out_free)
	);

	assign m_tdata = {7'b0, out_free, out_page};

endmodule

// ----- test/tb_top.sv -----
// Testbench for the page frame bitmap allocator: random requests checked by a predictor.
`timescale 1ns / 1ps

// Predicted allocator state and the queue of responses still owed by the block.
class alloc_scoreboard;
	bit          used_map [4096];
	int unsigned hint;
	int unsigned total_cfg;
	logic [1:0]  exp_status [$];
	logic [11:0] exp_page [$];
	logic [12:0] exp_free [$];
	int          errors;

	function new();
		hint      = 0;
		total_cfg = 4096;
		errors    = 0;
		foreach (used_map[i])
			used_map[i] = 1'b0;
	endfunction

	function int unsigned eff_total();
		return (total_cfg > 4096) ? 4096 : total_cfg;
	endfunction

	function bit span_clear(int unsigned start, int unsigned len);
		for (int unsigned i = 0; i < len; i++)
			if (used_map[start + i])
				return 1'b0;
		return 1'b1;
	endfunction

	function bit span_taken(int unsigned start, int unsigned len);
		for (int unsigned i = 0; i < len; i++)
			if (!used_map[start + i])
				return 1'b0;
		return 1'b1;
	endfunction

	function void paint(int unsigned start, int unsigned len, bit v);
		for (int unsigned i = 0; i < len; i++)
			used_map[start + i] = v;
	endfunction

	// Predicts the response to one accepted request and queues it; returns status and page.
	function void note_request(input logic [1:0] op, input logic [11:0] pg,
			input logic [10:0] ln, output logic [1:0] st, output logic [11:0] res);
		int unsigned tot;
		int unsigned len;
		int unsigned page;
		int unsigned nfree;
		bit          found;
		tot   = eff_total();
		len   = ln;
		page  = pg;
		st    = pfba_pkg::ST_OK;
		res   = '0;
		found = 1'b0;
		if (op == pfba_pkg::OP_NONE) begin
			st = pfba_pkg::ST_BUSY;
		end else if (len == 0 || len > 1024) begin
			st = pfba_pkg::ST_RANGE;
		end else if (op == pfba_pkg::OP_ALLOC) begin
			for (int unsigned p = hint; p < tot; p++) begin
				if (p % len != 0)
					continue;
				if (len > tot - p)
					break;
				if (span_clear(p, len)) begin
					paint(p, len, 1'b1);
					res   = p[11:0];
					found = 1'b1;
					break;
				end
			end
			// hint moves even when the alloc fails
			while (hint < tot && used_map[hint])
				hint++;
			if (!found)
				st = pfba_pkg::ST_BUSY;
		end else if (page >= tot || len > tot - page) begin
			st = pfba_pkg::ST_RANGE;
		end else if (op == pfba_pkg::OP_FREE) begin
			if (!span_taken(page, len)) begin
				st = pfba_pkg::ST_DOUBLE;
			end else begin
				paint(page, len, 1'b0);
				if (page < hint)
					hint = page;
			end
		end else begin
			if (!span_clear(page, len))
				st = pfba_pkg::ST_BUSY;
			else
				paint(page, len, 1'b1);
		end
		nfree = 0;
		for (int unsigned i = 0; i < tot; i++)
			if (!used_map[i])
				nfree++;
		exp_status.insert(exp_status.size(), st);
		exp_page.insert(exp_page.size(), res);
		exp_free.insert(exp_free.size(), nfree[12:0]);
	endfunction

	// Compares one accepted response with the oldest prediction.
	function void check_response(logic [1:0] st, logic [11:0] pg, logic [12:0] nfree);
		logic [1:0]  e_st;
		logic [11:0] e_pg;
		logic [12:0] e_free;
		if (exp_status.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected response: status %0d page %0d free %0d", st, pg, nfree);
			return;
		end
		e_st   = exp_status.pop_front();
		e_pg   = exp_page.pop_front();
		e_free = exp_free.pop_front();
		if (st !== e_st || pg !== e_pg || nfree !== e_free) begin
			errors++;
			if (errors <= 10)
				$display("mismatch: status %0d/%0d page %0d/%0d free %0d/%0d (exp/act)",
					e_st, st, e_pg, pg, e_free, nfree);
		end
	endfunction

	function int pending();
		return exp_status.size();
	endfunction
endclass

module tb_top;
	import pfba_pkg::*;

	localparam int WATCHDOG_LIMIT = 400000;
	localparam int SETTLE_CYCLES  = 40;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [23:0]        s_tdata;    // start_page[11:0], run_length[22:12]
	logic [1:0]         s_tuser;    // operation[1:0]
	logic               m_tvalid;
	logic               m_tready;
	logic [31:0]        m_tdata;    // result_page[11:0], free_pages[24:12]
	logic [1:0]         m_tuser;    // status[1:0]
	logic               cfg_valid;
	logic               cfg_ready;
	logic [TOTAL_W-1:0] cfg_data;

	alloc_scoreboard sb;

	// allocated runs still live, so random frees mostly hit real runs
	int unsigned live_page [$];
	int unsigned live_len [$];

	logic [7:0] stall_pattern;
	int         stall_phase;
	int         idle_cycles;

	page_frame_bitmap_allocator i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #6 clk = ~clk;

	// receiver: rotating stall pattern; all ones gives no stall at all
	always @(negedge clk) begin
		m_tready    <= stall_pattern[stall_phase];
		stall_phase <= (stall_phase + 1) % 8;
	end

	// response monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_response(m_tuser, m_tdata[11:0], m_tdata[24:12]);
	end

	// watchdog: cycles with no handshake on any channel
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
				|| !arst_n) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// one request; called at a falling edge, returns at a falling edge with valid still high
	task automatic send_request(logic [1:0] op, logic [11:0] pg, logic [10:0] ln);
		logic [1:0]  st;
		logic [11:0] res;
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {1'b0, ln, pg};
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_request(op, pg, ln, st, res);
		if (op == OP_ALLOC && st == ST_OK) begin
			live_page.insert(live_page.size(), res);
			live_len.insert(live_len.size(), ln);
		end
		@(negedge clk);
	endtask

	// sender gap between bursts
	task automatic pause_sender(int n);
		s_tvalid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// hold off until every response is in, then let the block wind down
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_total(logic [TOTAL_W-1:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.total_cfg = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// random traffic: mostly alloc/free of live runs, some reserves and noise
	task automatic random_traffic(int count, int max_len);
		int          burst;
		int          k;
		int unsigned tot;
		int unsigned sel;
		logic [11:0] pg;
		logic [10:0] ln;
		tot   = sb.eff_total();
		burst = $urandom_range(1, 8);
		for (int n = 0; n < count; n++) begin
			sel = $urandom_range(0, 99);
			ln  = 11'($urandom_range(1, max_len));
			pg  = (tot > 0) ? 12'($urandom_range(0, tot - 1)) : 12'($urandom_range(0, 4095));
			if (sel < 40) begin
				send_request(OP_ALLOC, 12'($urandom), ln);
			end else if (sel < 70 && live_page.size() > 0) begin
				k = $urandom_range(0, live_page.size() - 1);
				send_request(OP_FREE, 12'(live_page[k]), 11'(live_len[k]));
				live_page.delete(k);
				live_len.delete(k);
			end else if (sel < 85) begin
				send_request(OP_RESERVE, pg, ln);
			end else begin
				// noise across whole field ranges
				send_request(2'($urandom_range(0, 3)), 12'($urandom), 11'($urandom));
			end
			burst--;
			if (burst == 0) begin
				burst = $urandom_range(1, 8);
				if ($urandom_range(0, 2) == 0)
					pause_sender($urandom_range(1, 12));
			end
		end
	endtask

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = OP_ALLOC;
		m_tready      = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		stall_pattern = 8'hFF;
		stall_phase   = 0;
		idle_cycles   = 0;
		sb            = new();
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// directed: field extremes, every op, bad lengths, busy, double free, range
		send_request(OP_ALLOC, 12'd0, 11'd1);
		send_request(OP_ALLOC, 12'hFFF, 11'd1024);
		send_request(OP_ALLOC, 12'd0, 11'd0);
		send_request(OP_ALLOC, 12'd0, 11'd2047);
		send_request(OP_RESERVE, 12'd5, 11'd1025);
		send_request(OP_NONE, 12'hFFF, 11'h7FF);
		send_request(OP_FREE, 12'hFFF, 11'd1);
		send_request(OP_FREE, 12'd0, 11'd1);
		send_request(OP_FREE, 12'd0, 11'd1);
		send_request(OP_RESERVE, 12'hFFF, 11'd1);
		send_request(OP_RESERVE, 12'hFFF, 11'd1);
		send_request(OP_RESERVE, 12'hFFF, 11'd2);
		send_request(OP_FREE, 12'hFFF, 11'd1);
		send_request(OP_RESERVE, 12'd2048, 11'd1024);
		send_request(OP_ALLOC, 12'd0, 11'd1024);
		send_request(OP_FREE, 12'd1024, 11'd1024);
		send_request(OP_FREE, 12'd2047, 11'd2);
		send_request(OP_ALLOC, 12'd0, 11'd3);

		// total of zero manages nothing
		write_total(13'd0);
		stall_pattern = 8'b1011_0110;
		send_request(OP_ALLOC, 12'd0, 11'd1);
		send_request(OP_FREE, 12'd0, 11'd1);
		send_request(OP_RESERVE, 12'd0, 11'd1);

		// a single page: second alloc fails
		write_total(13'd1);
		send_request(OP_ALLOC, 12'd0, 11'd1);
		send_request(OP_ALLOC, 12'd0, 11'd1);
		send_request(OP_RESERVE, 12'd0, 11'd1);

		// lowered total with pages used above it
		write_total(13'd64);
		stall_pattern = 8'($urandom);
		random_traffic(20, 8);

		write_total(13'd37);
		stall_pattern = 8'hFF;
		random_traffic(25, 6);

		// total above the map size clamps to the map
		write_total(13'h1FFF);
		stall_pattern = 8'($urandom) | 8'h01;
		random_traffic(10, 64);

		write_total(13'd4096);
		stall_pattern = 8'($urandom);
		random_traffic(10, 16);

		write_total(13'd200);
		stall_pattern = 8'hFF;
		random_traffic(15, 10);

		drain();
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
